[sv/mexp_pkg.sv]
// Package for the modular exponentiation block.
// Holds configuration register indexes and reset constants.
// No dependencies.
package mexp_pkg;

  // Configuration register map
  localparam int unsigned CFG_IDX_BITS = 2;

  typedef enum logic [CFG_IDX_BITS-1:0] {
    CFG_EXPONENT = 2'd0,
    CFG_MODULUS  = 2'd1
  } cfg_idx_t;

  // Reset values, cut to the operand width by the top level
  localparam logic [31:0] EXPONENT_RESET = 32'd65537;
  localparam logic [31:0] MODULUS_RESET  = 32'd1;

endpackage

[sv/mexp_mulmod.sv]
// Bit-serial modular multiplier: result = (a * b) mod m, one bit of a per cycle.
// Requires b <= m and m >= 1. After start, done pulses once.
// No package dependencies.
module mexp_mulmod #(
  parameter int unsigned N = 31
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         start,
  input  logic [N-1:0] op_a,
  input  logic [N-1:0] op_b,
  input  logic [N-1:0] op_m,
  output logic         done,
  output logic [N-1:0] result
);

  localparam int unsigned CW = (N > 1) ? $clog2(N) : 1;

  logic         busy_r;
  logic         done_r;
  logic [CW-1:0] cnt_r;
  logic [N-1:0] a_sh_r;
  logic [N-1:0] b_r;
  logic [N-1:0] m_r;
  logic [N-1:0] acc_r;
  logic [N-1:0] acc_nxt;

  logic [N+1:0] sum;
  logic [N+1:0] m1;
  logic [N+1:0] m2;

  // One step: acc = 2*acc + bit*b, then bring back below m (at most 2m off)
  always_comb begin
    sum = {1'b0, acc_r, 1'b0} + (a_sh_r[N-1] ? {2'b00, b_r} : '0);
    m1  = {2'b00, m_r};
    m2  = {1'b0, m_r, 1'b0};
    if (sum >= m2) begin
      acc_nxt = N'(sum - m2);
    end else if (sum >= m1) begin
      acc_nxt = N'(sum - m1);
    end else begin
      acc_nxt = sum[N-1:0];
    end
  end

  // Control: bit counter and done pulse
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= CW'(N - 1);
      end else if (busy_r) begin
        if (cnt_r == '0) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end else begin
          cnt_r <= cnt_r - 1'b1;
        end
      end
    end
  end

  // Datapath: operand latch and serial accumulate, MSB of a first
  always_ff @(posedge clk) begin
    if (start) begin
      a_sh_r <= op_a;
      b_r    <= op_b;
      m_r    <= op_m;
      acc_r  <= '0;
    end else if (busy_r) begin
      a_sh_r <= {a_sh_r[N-2:0], 1'b0};
      acc_r  <= acc_nxt;
    end
  end

  assign done   = done_r;
  assign result = acc_r;

endmodule

[sv/modular_exponentiation.sv]
// Top level of the modular exponentiation block (right-to-left square and multiply).
// Uses mexp_pkg and two mexp_mulmod bit-serial multipliers.
//
//   channel | direction | handshake           | payload
//   in_     | input     | in_valid / in_stall | in_base_value
//   out_    | output    | out_valid/out_stall | out_power_residue
//   cfg_    | input     | cfg_valid/cfg_ready | cfg_index, cfg_wdata
//
// Sequence: the base is first reduced mod m, then each exponent bit up to the
// highest set one takes one multiply and square step (run side by side in
// the two serial multipliers), then the finish step loads the output register.
// Exponent zero skips the reduction and goes straight to the finish step.
// Reset is synchronous, active low; configuration returns to 65537 and 1.
// An item is taken only while idle; a finished result waits in the output
// register under out_stall while the next item is already accepted, and the
// finish step holds while that register is still full and stalled.
module modular_exponentiation
  import mexp_pkg::*;
#(
  parameter int unsigned OPERAND_BITS = 31
) (
  input  logic                    clk,
  input  logic                    rst_n,
  // input channel
  input  logic                    in_valid,
  output logic                    in_stall,
  input  logic [OPERAND_BITS-1:0] in_base_value,
  // result channel
  output logic                    out_valid,
  input  logic                    out_stall,
  output logic [OPERAND_BITS-1:0] out_power_residue,
  // configuration channel
  input  logic                    cfg_valid,
  output logic                    cfg_ready,
  input  logic [CFG_IDX_BITS-1:0] cfg_index,
  input  logic [OPERAND_BITS-1:0] cfg_wdata
);

  localparam int unsigned N = OPERAND_BITS;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_REDUCE,
    ST_ISSUE,
    ST_WAIT,
    ST_FINISH
  } state_t;

  state_t       state_r;
  logic [N-1:0] exponent_r;
  logic [N-1:0] modulus_r;
  logic [N-1:0] m_r;
  logic [N-1:0] exp_sh_r;
  logic [N-1:0] acc_r;
  logic [N-1:0] base_r;
  logic         out_valid_r;
  logic [N-1:0] out_power_residue_r;

  logic         in_xfer;
  logic [N-1:0] m_eff;
  logic         start_a;
  logic         start_b;
  logic [N-1:0] a_op_a;
  logic [N-1:0] a_op_b;
  logic [N-1:0] m_op;
  logic         done_a;
  logic         done_b;
  logic [N-1:0] res_a;
  logic [N-1:0] res_b;
  logic [N-1:0] exp_next;

  // Configuration registers; an item in flight works on its own copy of the key
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      exponent_r <= EXPONENT_RESET[N-1:0];
      modulus_r  <= MODULUS_RESET[N-1:0];
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_EXPONENT: exponent_r <= cfg_wdata;
        CFG_MODULUS:  modulus_r  <= cfg_wdata;
        default:      ;
      endcase
    end
  end

  // Input transfer and operand steering to the multipliers
  assign in_stall = (state_r != ST_IDLE);
  assign in_xfer  = in_valid && !in_stall;
  assign m_eff    = (modulus_r == '0) ? N'(1) : modulus_r;
  assign exp_next = exp_sh_r >> 1;

  always_comb begin
    start_a = (state_r == ST_IDLE && in_xfer && exponent_r != '0) ||
              (state_r == ST_ISSUE);
    start_b = (state_r == ST_ISSUE);
    if (state_r == ST_IDLE) begin
      // base mod m, computed as base * 1
      a_op_a = in_base_value;
      a_op_b = N'(1);
      m_op   = m_eff;
    end else begin
      a_op_a = acc_r;
      a_op_b = base_r;
      m_op   = m_r;
    end
  end

  // Unit A: reduction, then acc * base
  mexp_mulmod #(.N(N)) u_mul_acc (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (start_a),
    .op_a   (a_op_a),
    .op_b   (a_op_b),
    .op_m   (m_op),
    .done   (done_a),
    .result (res_a)
  );

  // Unit B: base * base
  mexp_mulmod #(.N(N)) u_mul_sq (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (start_b),
    .op_a   (base_r),
    .op_b   (base_r),
    .op_m   (m_r),
    .done   (done_b),
    .result (res_b)
  );

  // Sequencer with output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      // the finish step reloads the output register itself
      if (out_valid_r && !out_stall && state_r != ST_FINISH) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        ST_IDLE: begin
          if (in_xfer) begin
            m_r      <= m_eff;
            exp_sh_r <= exponent_r;
            acc_r    <= N'(1);
            // exponent zero leaves the result at 1, unreduced
            state_r  <= (exponent_r == '0) ? ST_FINISH : ST_REDUCE;
          end
        end
        ST_REDUCE: begin
          if (done_a) begin
            base_r  <= res_a;
            state_r <= ST_ISSUE;
          end
        end
        ST_ISSUE: begin
          state_r <= ST_WAIT;
        end
        ST_WAIT: begin
          // both units finish on the same cycle
          if (done_b) begin
            if (exp_sh_r[0]) begin
              acc_r <= res_a;
            end
            base_r   <= res_b;
            exp_sh_r <= exp_next;
            state_r  <= (exp_next == '0) ? ST_FINISH : ST_ISSUE;
          end
        end
        ST_FINISH: begin
          if (!out_valid_r || !out_stall) begin
            out_valid_r         <= 1'b1;
            out_power_residue_r <= acc_r;
            state_r             <= ST_IDLE;
          end
        end
        default: begin
          state_r <= ST_IDLE;
        end
      endcase
    end
  end

  assign out_valid         = out_valid_r;
  assign out_power_residue = out_power_residue_r;

endmodule
